>>> rtl/ird_pkg.sv
package ird_pkg;

  // Fixed field widths of the stream words.
  localparam int STAMP_W    = 16;
  localparam int COUNT_W    = 6;
  localparam int CODE_OUT_W = 16;
  localparam int PHASE_W    = 2;
  localparam int CFG_IDX_W  = 2;

  // Default frame geometry.
  localparam int FRAME_BITS_DEF = 32;
  localparam int CODE_WIDTH_DEF = 16;

  // Register reset values in microseconds.
  localparam logic [STAMP_W-1:0] LEADER_MARK_RESET = 16'd9000;
  localparam logic [STAMP_W-1:0] LEADER_GAP_RESET  = 16'd4000;
  localparam logic [STAMP_W-1:0] ONE_THRESH_RESET  = 16'd200;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LEADER_MARK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEADER_GAP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_THRESH  = 2'd2;

  // Decoder phase; the unused code is treated as idle.
  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE = 2'd0,
    PH_GAP  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  // Timing thresholds.
  typedef struct packed {
    logic [STAMP_W-1:0] leader_mark_min;
    logic [STAMP_W-1:0] leader_gap_min;
    logic [STAMP_W-1:0] one_threshold;
  } cfg_t;

  // One result word.
  typedef struct packed {
    logic                  frame_done;
    logic [CODE_OUT_W-1:0] code_word;
    logic [PHASE_W-1:0]    decoder_phase;
    logic [COUNT_W-1:0]    bit_count;
  } result_t;

endpackage

>>> rtl/ird_step.sv
module ird_step #(
  parameter int FRAME_BITS = ird_pkg::FRAME_BITS_DEF,
  parameter int CODE_WIDTH = ird_pkg::CODE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          pin_level,
  input  logic [ird_pkg::STAMP_W-1:0]   edge_time,
  input  ird_pkg::cfg_t                 cfg,
  output ird_pkg::result_t              res
);
  import ird_pkg::*;

  phase_t                phase, phase_next;
  logic [STAMP_W-1:0]    rise_stamp, rise_stamp_next;
  logic [STAMP_W-1:0]    fall_stamp, fall_stamp_next;
  logic [COUNT_W-1:0]    bits_seen, bits_seen_next;
  logic [CODE_WIDTH-1:0] code_shift, code_shift_next;
  logic [CODE_WIDTH-1:0] code_shifted;
  logic [STAMP_W-1:0]    since_rise, since_fall;
  logic                  frame_full, frame_end, done;

  // Durations wrap modulo the timestamp width.
  assign since_rise = edge_time - rise_stamp;
  assign since_fall = edge_time - fall_stamp;
  assign frame_full = (bits_seen == COUNT_W'(FRAME_BITS));
  assign frame_end  = (bits_seen >= COUNT_W'(FRAME_BITS));

  // New bit enters at the top as the code shifts right.
  always_comb begin
    code_shifted = code_shift >> 1;
    code_shifted[CODE_WIDTH-1] = (since_fall > cfg.one_threshold);
  end

  // Next phase.
  always_comb begin
    unique case (phase)
      PH_GAP: begin
        if (pin_level && (since_fall > cfg.leader_gap_min)) begin
          phase_next = PH_DATA;
        end else begin
          phase_next = PH_IDLE;
        end
      end
      PH_DATA: begin
        if (!pin_level && frame_full) begin
          phase_next = PH_IDLE;
        end else begin
          phase_next = PH_DATA;
        end
      end
      default: begin
        if (!pin_level && (since_rise > cfg.leader_mark_min)) begin
          phase_next = PH_GAP;
        end else begin
          phase_next = PH_IDLE;
        end
      end
    endcase
  end

  // Timestamps, bit counter, code register and frame flag.
  always_comb begin
    rise_stamp_next = rise_stamp;
    fall_stamp_next = fall_stamp;
    bits_seen_next  = bits_seen;
    code_shift_next = code_shift;
    done            = 1'b0;
    unique case (phase)
      PH_GAP: begin
        if (pin_level) begin
          rise_stamp_next = edge_time;
        end
      end
      PH_DATA: begin
        if (pin_level) begin
          rise_stamp_next = edge_time;
          if (!frame_end) begin
            code_shift_next = code_shifted;
            bits_seen_next  = bits_seen + COUNT_W'(1);
          end
        end else begin
          fall_stamp_next = edge_time;
          done            = frame_full;
        end
      end
      default: begin
        if (pin_level) begin
          rise_stamp_next = edge_time;
          bits_seen_next  = '0;
          code_shift_next = '0;
        end else begin
          fall_stamp_next = edge_time;
        end
      end
    endcase
  end

  // Decoder state advances once per accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      rise_stamp <= '0;
      fall_stamp <= '0;
      bits_seen  <= '0;
      code_shift <= '0;
    end else if (en) begin
      phase      <= phase_next;
      rise_stamp <= rise_stamp_next;
      fall_stamp <= fall_stamp_next;
      bits_seen  <= bits_seen_next;
      code_shift <= code_shift_next;
    end
  end

  // Result reflects the state after this edge.
  generate
    if (CODE_WIDTH >= CODE_OUT_W) begin : g_code_trunc
      assign res.code_word = code_shift_next[CODE_OUT_W-1:0];
    end else begin : g_code_ext
      assign res.code_word = CODE_OUT_W'(code_shift_next);
    end
  endgenerate

  assign res.frame_done    = done;
  assign res.decoder_phase = phase_next;
  assign res.bit_count     = bits_seen_next;

endmodule

>>> rtl/ir_pulse_distance_decoder_unit.sv
// Pulse-distance infrared frame decoder.
// The slave stream carries one pin edge per word: the level after the edge
// and a 16-bit microsecond timestamp. Each accepted edge yields exactly one
// master word with the decoder phase, bit count and code register after that
// edge; tlast is high on the word whose falling edge completes a frame.
// A leader mark, then a leader gap, start a frame; each later low space is
// one bit, shifted in at the top of the code register.
// Output is valid in the cycle after input accept. One edge is taken every
// cycle while the receiver keeps up: the phase, timestamps and code register
// update in a single combinational pass of subtracts, compares and a shift.
// When the receiver stalls, the result word holds and the slave side stalls
// with it; a new edge is accepted in the same cycle the held word is taken.
// Reset clears the phase to idle, the timestamps, bit count and code to zero,
// restores the default thresholds (9000, 4000 and 200 microseconds) and
// empties the result register. Thresholds are written through
// cfg_we/cfg_addr/cfg_wdata while idle; the block itself does not enforce this.
module ir_pulse_distance_decoder_unit #(
  parameter int FRAME_BITS = ird_pkg::FRAME_BITS_DEF,
  parameter int CODE_WIDTH = ird_pkg::CODE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Slave stream: bit 0 pin_level, bits 16:1 edge_time, bits 23:17 zero.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [23:0]                   s_tdata,
  // Master stream: bits 15:0 code_word, bits 17:16 decoder_phase,
  // bits 23:18 bit_count.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [23:0]                   m_tdata,
  output logic                          m_tlast,
  // Configuration write port.
  input  logic                          cfg_we,
  input  logic [ird_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [ird_pkg::STAMP_W-1:0]   cfg_wdata
);
  import ird_pkg::*;

  cfg_t    cfg;
  result_t step_res;
  result_t out_res;
  logic    out_valid;
  logic    accept;

  // Input is taken whenever the result register is empty or being drained.
  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Threshold registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.leader_mark_min <= LEADER_MARK_RESET;
      cfg.leader_gap_min  <= LEADER_GAP_RESET;
      cfg.one_threshold   <= ONE_THRESH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LEADER_MARK: cfg.leader_mark_min <= cfg_wdata;
        REG_LEADER_GAP:  cfg.leader_gap_min  <= cfg_wdata;
        REG_ONE_THRESH:  cfg.one_threshold   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  ird_step #(
    .FRAME_BITS (FRAME_BITS),
    .CODE_WIDTH (CODE_WIDTH)
  ) u_step (
    .clk       (clk),
    .rst       (rst),
    .en        (accept),
    .pin_level (s_tdata[0]),
    .edge_time (s_tdata[STAMP_W:1]),
    .cfg       (cfg),
    .res       (step_res)
  );

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_res <= step_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_res.frame_done;
  assign m_tdata  = {out_res.bit_count, out_res.decoder_phase, out_res.code_word};

endmodule

>>> sim/tb_ir_pulse_distance_decoder_unit.sv
module tb_ir_pulse_distance_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ird_pkg::*;

  localparam int FRAME_BITS     = FRAME_BITS_DEF;
  localparam int CODE_WIDTH     = CODE_WIDTH_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;

  // One pin edge as it travels on the slave stream.
  typedef struct packed {
    logic               level;
    logic [STAMP_W-1:0] stamp;
  } pin_edge_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Slave stream: bit 0 pin_level, bits 16:1 edge_time, bits 23:17 zero.
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;
  // Master stream: bits 15:0 code_word, bits 17:16 decoder_phase,
  // bits 23:18 bit_count.
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;

  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr  = REG_LEADER_MARK;
  logic [STAMP_W-1:0]   cfg_wdata = '0;

  ir_pulse_distance_decoder_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Edges waiting to be sent and decoder words waiting to be seen.
  pin_edge_t edge_queue[$];
  result_t   pending_results[$];

  // Shadow of the decoder: thresholds and frame state.
  cfg_t                  thresholds = '{LEADER_MARK_RESET, LEADER_GAP_RESET, ONE_THRESH_RESET};
  phase_t                dec_phase  = PH_IDLE;
  logic [STAMP_W-1:0]    rise_us    = '0;
  logic [STAMP_W-1:0]    fall_us    = '0;
  logic [COUNT_W-1:0]    bits_held  = '0;
  logic [CODE_WIDTH-1:0] code_reg   = '0;

  int mismatches = 0;
  int idle_cycles = 0;
  bit took_edge = 1'b0;

  // Stimulus bookkeeping.
  logic [STAMP_W-1:0] clock_us = '0;
  int queued_edges = 0;
  int hold_req = 0;

  // Updates the shadow state for one edge and returns the word it yields.
  function automatic result_t decode_edge(input logic level, input logic [STAMP_W-1:0] stamp);
    logic [STAMP_W-1:0] since_fall;
    logic [STAMP_W-1:0] since_rise;
    result_t word;
    since_fall = stamp - fall_us;
    since_rise = stamp - rise_us;
    word = '0;
    case (dec_phase)
      PH_GAP: begin
        if (level) begin
          rise_us = stamp;
          dec_phase = (since_fall > thresholds.leader_gap_min) ? PH_DATA : PH_IDLE;
        end else begin
          dec_phase = PH_IDLE;
        end
      end
      PH_DATA: begin
        if (level) begin
          rise_us = stamp;
          // Once the frame is full, extra rising edges only move the rise stamp.
          if (bits_held < COUNT_W'(FRAME_BITS)) begin
            code_reg = {since_fall > thresholds.one_threshold, code_reg[CODE_WIDTH-1:1]};
            bits_held = bits_held + COUNT_W'(1);
          end
        end else begin
          fall_us = stamp;
          if (bits_held == COUNT_W'(FRAME_BITS)) begin
            dec_phase = PH_IDLE;
            word.frame_done = 1'b1;
          end
        end
      end
      default: begin
        dec_phase = PH_IDLE;
        if (level) begin
          rise_us = stamp;
          bits_held = '0;
          code_reg = '0;
        end else begin
          fall_us = stamp;
          if (since_rise > thresholds.leader_mark_min) dec_phase = PH_GAP;
        end
      end
    endcase
    word.code_word = code_reg[CODE_OUT_W-1:0];
    word.decoder_phase = dec_phase;
    word.bit_count = bits_held;
    return word;
  endfunction

  // Edge driver: bursts of words with random gaps, changing on the falling clock.
  int burst_left = 1;
  int gap_left = 0;
  pin_edge_t next_edge;

  always @(negedge clk) begin
    if (!rst && !(s_tvalid && !took_edge)) begin
      if (gap_left > 0) begin
        s_tvalid <= 1'b0;
        gap_left--;
      end else if (edge_queue.size() > 0) begin
        next_edge = edge_queue.pop_front();
        s_tdata <= {7'd0, next_edge.stamp, next_edge.level};
        s_tvalid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: its own stall pattern, plus a long hold-off on request.
  int hold_seen = 0;
  int hold_left = 0;
  int seg_left = 0;
  int rx_mode = 0;

  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 80);
        rx_mode = $urandom_range(0, 3);
      end
      seg_left--;
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= ~m_tready;
      endcase
    end
  end

  // Monitor: predicts on every accepted edge and checks every taken word.
  result_t want;

  always @(posedge clk) begin
    if (rst) begin
      took_edge = 1'b0;
    end else begin
      took_edge = s_tvalid && s_tready;
      if (took_edge) pending_results.push_back(decode_edge(s_tdata[0], s_tdata[16:1]));
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result word %h last %b", m_tdata, m_tlast);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (m_tlast !== want.frame_done) begin
            $error("frame_done expected %0d got %0d", want.frame_done, m_tlast);
            mismatches++;
          end
          if (m_tdata[15:0] !== want.code_word) begin
            $error("code_word expected %h got %h", want.code_word, m_tdata[15:0]);
            mismatches++;
          end
          if (m_tdata[17:16] !== want.decoder_phase) begin
            $error("decoder_phase expected %0d got %0d", want.decoder_phase, m_tdata[17:16]);
            mismatches++;
          end
          if (m_tdata[23:18] !== want.bit_count) begin
            $error("bit_count expected %0d got %0d", want.bit_count, m_tdata[23:18]);
            mismatches++;
          end
        end
      end
      // Watchdog on cycles where neither side moves a word.
      if (took_edge || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("ir_pulse_distance_decoder_unit verification failed");
        $finish;
      end
    end
  end

  // Stimulus helpers.
  task automatic push_at(input logic level, input int stamp);
    clock_us = stamp[STAMP_W-1:0];
    edge_queue.push_back(pin_edge_t'{level, clock_us});
    queued_edges++;
  endtask

  task automatic push_rel(input logic level, input int delta);
    push_at(level, int'(clock_us) + delta);
  endtask

  // A duration that just beats the given threshold, where one exists.
  function automatic int over_val(input int lim);
    int room;
    room = 65534 - lim;
    if (lim >= 65535) return 65535;
    return lim + 1 + $urandom_range(0, (room < 400) ? room : 400);
  endfunction

  // A duration at or just below the given threshold.
  function automatic int under_val(input int lim);
    if (lim == 0) return 0;
    return $urandom_range((lim > 300) ? lim - 300 : 0, lim);
  endfunction

  // Leader plus data bits; a cut below FRAME_BITS leaves the frame unfinished.
  task automatic add_frame(input int cut, input bit extra_rise);
    int i;
    push_rel(1'b1, $urandom_range(1, 30000));
    push_rel(1'b0, over_val(int'(thresholds.leader_mark_min)));
    push_rel(1'b1, over_val(int'(thresholds.leader_gap_min)));
    for (i = 0; i < FRAME_BITS; i++) begin
      if (i == cut) return;
      push_rel(1'b0, $urandom_range(0, 700));
      push_rel(1'b1, $urandom_range(0, 1) ? over_val(int'(thresholds.one_threshold))
                                          : under_val(int'(thresholds.one_threshold)));
    end
    if (extra_rise) push_rel(1'b1, $urandom_range(0, 2000));
    push_rel(1'b0, $urandom_range(0, 700));
    // A stray falling edge in idle leaves the received code in place.
    if ($urandom_range(0, 3) == 0) push_rel(1'b0, $urandom_range(0, 65535));
  endtask

  // Malformed leaders and plain noise.
  task automatic add_noise();
    int n;
    int i;
    case ($urandom_range(0, 2))
      0: begin
        push_rel(1'b1, $urandom_range(0, 65535));
        push_rel(1'b0, under_val(int'(thresholds.leader_mark_min)));
      end
      1: begin
        push_rel(1'b1, $urandom_range(0, 65535));
        push_rel(1'b0, over_val(int'(thresholds.leader_mark_min)));
        if ($urandom_range(0, 1)) push_rel(1'b0, $urandom_range(0, 65535));
        else push_rel(1'b1, under_val(int'(thresholds.leader_gap_min)));
      end
      default: begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) push_rel(1'($urandom_range(0, 1)), $urandom_range(0, 65535));
      end
    endcase
  endtask

  // Blocks until the decoder holds nothing and nothing is left to send.
  // Checked at the rising edge, where the driver's queue and valid are settled.
  task automatic wait_drained();
    while (edge_queue.size() != 0 || s_tvalid || m_tvalid || pending_results.size() != 0)
      @(posedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_thresholds(input int mark, input int gap, input int one);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= REG_LEADER_MARK;
    cfg_wdata <= mark[STAMP_W-1:0];
    thresholds.leader_mark_min = mark[STAMP_W-1:0];
    @(negedge clk);
    cfg_addr <= REG_LEADER_GAP;
    cfg_wdata <= gap[STAMP_W-1:0];
    thresholds.leader_gap_min = gap[STAMP_W-1:0];
    @(negedge clk);
    cfg_addr <= REG_ONE_THRESH;
    cfg_wdata <= one[STAMP_W-1:0];
    thresholds.one_threshold = one[STAMP_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int budget);
    int r;
    queued_edges = 0;
    while (queued_edges < budget) begin
      r = $urandom_range(0, 9);
      if (r < 7) add_frame(FRAME_BITS, $urandom_range(0, 3) == 0);
      else if (r == 7) add_frame($urandom_range(0, FRAME_BITS - 1), 1'b0);
      else add_noise();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed edges at the reset thresholds.
    push_at(1'b0, 9001);    // leader mark measured from the reset rise stamp
    push_at(1'b0, 9100);    // falling edge in leader gap abandons the frame
    push_at(1'b1, 100);
    push_at(1'b0, 9100);    // mark exactly at threshold stays idle
    push_at(1'b1, 65000);
    push_at(1'b0, 8965);    // mark across the timestamp wrap
    push_at(1'b1, 12965);   // gap exactly at threshold returns to idle
    push_at(1'b1, 0);
    push_at(1'b0, 9001);
    push_at(1'b1, 13002);   // gap just over threshold starts data
    push_at(1'b0, 13500);
    push_at(1'b1, 13701);   // space just over one threshold
    push_at(1'b0, 14000);
    push_at(1'b1, 14200);   // space exactly at one threshold
    push_at(1'b0, 65535);
    push_at(1'b1, 65535);   // zero-length space
    push_at(1'b0, 0);
    push_at(1'b1, 65535);   // longest possible space
    // Finish the frame, with extra rising edges once it is full.
    for (int i = 4; i < FRAME_BITS; i++) begin
      push_rel(1'b0, 560);
      push_rel(1'b1, ($urandom_range(0, 1)) ? 1690 : 560);
    end
    push_rel(1'b1, 100);
    push_rel(1'b1, 100);
    push_rel(1'b0, 560);
    push_rel(1'b0, 20000);

    // Random phases over several threshold settings.
    set_thresholds(int'(LEADER_MARK_RESET), int'(LEADER_GAP_RESET), int'(ONE_THRESH_RESET));
    run_phase(300);
    set_thresholds(0, 0, 0);
    run_phase(300);
    set_thresholds(65535, 65535, 65535);
    run_phase(60);
    set_thresholds($urandom_range(1, 3000), $urandom_range(1, 3000), $urandom_range(1, 2000));
    run_phase(300);
    set_thresholds(65534, 65534, 65534);
    run_phase(250);
    set_thresholds($urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535));
    run_phase(300);
    set_thresholds(int'(LEADER_MARK_RESET), int'(LEADER_GAP_RESET), int'(ONE_THRESH_RESET));
    run_phase(300);
    // Long receiver hold-off while the edge queue is still full.
    @(posedge clk);
    hold_req++;

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("ir_pulse_distance_decoder_unit verification clean");
    end else begin
      $display("ir_pulse_distance_decoder_unit verification failed");
    end
    $finish;
  end

endmodule
